### design/lvm_pkg.sv
`default_nettype none

package lvm_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CW        = 30;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int NORM_LAT  = 58;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [2:0] vec3_t;
    typedef logic [63:0] mag_t;
    typedef logic signed [63:0] prod_t;

    typedef struct packed {
        logic [2:0] neg;
        mag_t [2:0] mag;
    } wvec_t;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } nmeta_t;

endpackage

`default_nettype wire

### design/lvm_delay.sv
`default_nettype none

module lvm_delay #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 60
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d_i,
    output logic      [WIDTH-1:0] q_o
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= d_i;
            for (int k = 1; k < DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q_o = line_reg[DEPTH-1];

endmodule

`default_nettype wire

### design/lvm_norm.sv
`default_nettype none

module lvm_norm (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire lvm_pkg::wvec_t vec_i,
    output lvm_pkg::vec3_t     unit_o
);
    import lvm_pkg::*;

    mag_t [2:0]  a_mag_reg, a_mag_next;
    logic [2:0]  a_neg_reg, a_neg_next;
    mag_t        a_max_reg, a_max_next;

    mag_t [2:0]       b_mag_reg, b_mag_next;
    logic [2:0]       b_neg_reg, b_neg_next;
    logic [3:0]       b_nz_reg, b_nz_next;
    logic [3:0][3:0]  b_clz_reg, b_clz_next;

    mag_t [2:0]  c_mag_reg, c_mag_next;
    logic [2:0]  c_neg_reg, c_neg_next;
    logic        c_zero_reg, c_zero_next;
    logic [5:0]  c_lz_reg, c_lz_next;

    logic [2:0][CW-1:0] cval_reg [4:39];
    logic [2:0][CW-1:0] cval_next [4:39];
    nmeta_t             meta_reg [4:57];
    nmeta_t             meta_next [4:57];

    logic [2:0][2*CW-1:0] sq_reg, sq_next;
    logic [2*CW+1:0]      sum_reg, sum_next;

    logic [63:0] sqn_reg [SQ_STEPS];
    logic [63:0] sqn_next [SQ_STEPS];
    logic [63:0] sqr_reg [SQ_STEPS];
    logic [63:0] sqr_next [SQ_STEPS];

    logic [31:0] len_reg, len_next;
    logic [2:0][46:0] dd_reg, dd_next;
    logic [31:0]      dl_reg, dl_next;

    logic [2:0][46:0]       drem_reg [DIV_STEPS];
    logic [2:0][46:0]       drem_next [DIV_STEPS];
    logic [2:0][FRAC_W:0]   dq_reg [DIV_STEPS];
    logic [2:0][FRAC_W:0]   dq_next [DIV_STEPS];
    logic [31:0]            dlen_reg [DIV_STEPS];
    logic [31:0]            dlen_next [DIV_STEPS];

    vec3_t unit_reg, unit_next;

    always_comb begin
        mag_t        m01;
        logic [15:0] chunk;
        logic [63:0] sh;
        logic [63:0] bitv, trial, n_in, r_in;
        logic [46:0] rem;
        logic [47:0] dsh;
        logic [FRAC_W:0] q;
        logic [31:0] qe;

        m01 = (vec_i.mag[0] > vec_i.mag[1]) ? vec_i.mag[0] : vec_i.mag[1];
        a_max_next = (m01 > vec_i.mag[2]) ? m01 : vec_i.mag[2];
        a_mag_next = vec_i.mag;
        a_neg_next = vec_i.neg;

        b_mag_next = a_mag_reg;
        b_neg_next = a_neg_reg;
        for (int ch = 0; ch < 4; ch++) begin
            chunk = a_max_reg[16*ch +: 16];
            b_nz_next[ch] = |chunk;
            b_clz_next[ch] = 4'd0;
            for (int b = 0; b < 16; b++) begin
                if (chunk[b]) begin
                    b_clz_next[ch] = 4'(15 - b);
                end
            end
        end

        c_mag_next = b_mag_reg;
        c_neg_next = b_neg_reg;
        c_zero_next = ~|b_nz_reg;
        c_lz_next = 6'd0;
        for (int ch = 0; ch < 4; ch++) begin
            if (b_nz_reg[ch]) begin
                c_lz_next = {2'(3 - ch), b_clz_reg[ch]};
            end
        end

        for (int i = 0; i < 3; i++) begin
            sh = c_mag_reg[i] << c_lz_reg;
            cval_next[4][i] = sh[63:64-CW];
        end
        meta_next[4] = '{zero: c_zero_reg, neg: c_neg_reg};
        for (int k = 5; k <= 39; k++) begin
            cval_next[k] = cval_reg[k-1];
        end
        for (int k = 5; k <= 57; k++) begin
            meta_next[k] = meta_reg[k-1];
        end

        for (int i = 0; i < 3; i++) begin
            sq_next[i] = cval_reg[4][i] * cval_reg[4][i];
        end
        sum_next = (2*CW+2)'(sq_reg[0]) + (2*CW+2)'(sq_reg[1]) + (2*CW+2)'(sq_reg[2]);

        for (int j = 0; j < SQ_STEPS; j++) begin
            n_in = (j == 0) ? 64'(sum_reg) : sqn_reg[j-1];
            r_in = (j == 0) ? 64'd0 : sqr_reg[j-1];
            bitv = 64'd1 << (62 - 2*j);
            trial = r_in + bitv;
            if (n_in >= trial) begin
                sqn_next[j] = n_in - trial;
                sqr_next[j] = (r_in >> 1) + bitv;
            end else begin
                sqn_next[j] = n_in;
                sqr_next[j] = r_in >> 1;
            end
        end

        len_next = sqr_reg[SQ_STEPS-1][31:0]
                 + {31'd0, (sqn_reg[SQ_STEPS-1] > sqr_reg[SQ_STEPS-1])};

        for (int i = 0; i < 3; i++) begin
            dd_next[i] = {1'b0, cval_reg[39][i], 16'd0} + {16'd0, len_reg[31:1]};
        end
        dl_next = len_reg;

        for (int k = 0; k < DIV_STEPS; k++) begin
            dlen_next[k] = (k == 0) ? dl_reg : dlen_reg[k-1];
            dsh = {16'd0, dlen_next[k]} << (DIV_STEPS - 1 - k);
            for (int i = 0; i < 3; i++) begin
                rem = (k == 0) ? dd_reg[i] : drem_reg[k-1][i];
                q = (k == 0) ? '0 : dq_reg[k-1][i];
                if ({1'b0, rem} >= dsh) begin
                    rem = rem - dsh[46:0];
                    q[DIV_STEPS-1-k] = 1'b1;
                end
                drem_next[k][i] = rem;
                dq_next[k][i] = q;
            end
        end

        for (int i = 0; i < 3; i++) begin
            qe = 32'(dq_reg[DIV_STEPS-1][i]);
            if (meta_reg[57].zero) begin
                unit_next[i] = '0;
            end else if (meta_reg[57].neg[i]) begin
                unit_next[i] = -qe;
            end else begin
                unit_next[i] = qe;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_max_reg  <= a_max_next;
            b_mag_reg  <= b_mag_next;
            b_neg_reg  <= b_neg_next;
            b_nz_reg   <= b_nz_next;
            b_clz_reg  <= b_clz_next;
            c_mag_reg  <= c_mag_next;
            c_neg_reg  <= c_neg_next;
            c_zero_reg <= c_zero_next;
            c_lz_reg   <= c_lz_next;
            cval_reg   <= cval_next;
            meta_reg   <= meta_next;
            sq_reg     <= sq_next;
            sum_reg    <= sum_next;
            sqn_reg    <= sqn_next;
            sqr_reg    <= sqr_next;
            len_reg    <= len_next;
            dd_reg     <= dd_next;
            dl_reg     <= dl_next;
            drem_reg   <= drem_next;
            dq_reg     <= dq_next;
            dlen_reg   <= dlen_next;
            unit_reg   <= unit_next;
        end
    end

    assign unit_o = unit_reg;

endmodule

`default_nettype wire

### design/look_at_view_matrix.sv
`default_nettype none
// Throughput: one beat per cycle; the pipeline stalls only when both the output register
// and the skid register hold undelivered beats.
// The pipeline holds three normalisers, two of them chained (right, then up), each a 32-stage
// square root and a 17-stage divider, plus cross product and dot product stages.
// Reset clears the valid bits and inverse_mode; no clearing pass is needed.

module look_at_view_matrix (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,   // inverse_mode
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [287:0] s_tdata,     // look_x/y/z, up_hint_x/y/z, pos_x/y/z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [383:0]      m_tdata      // right, upward, forward, trans (x/y/z each)
);
    import lvm_pkg::*;

    localparam int PIPE_LAT = 124;
    localparam int LINE_LAT = NORM_LAT + 2;

    function automatic wvec_t cross_sm(input prod_t [5:0] p);
        wvec_t      r;
        logic [64:0] d;
        for (int i = 0; i < 3; i++) begin
            d = {p[2*i][63], p[2*i]} - {p[2*i+1][63], p[2*i+1]};
            r.neg[i] = d[64];
            r.mag[i] = d[64] ? 64'(-d) : d[63:0];
        end
        return r;
    endfunction

    logic en;
    logic inverse_mode_reg;
    logic [PIPE_LAT-1:0] vld_reg;

    logic [287:0] in_reg;
    vec3_t        look_w, hint_w;
    prod_t [5:0]  ca_reg, ca_next;
    wvec_t        fw_reg, fw_next;
    wvec_t        rv_reg, fw3_reg;

    vec3_t right_w, fwd_w, look_d, up_w, right_d, fwd_d, pos_d;
    prod_t [5:0] cu_reg, cu_next;
    wvec_t       uv_reg;

    logic signed [48:0] dp_reg [9];
    logic signed [48:0] dp_next [9];
    logic signed [50:0] ds_reg [3];
    logic signed [50:0] ds_next [3];
    logic [33:0]        dq_reg [3];
    logic [33:0]        dq_next [3];
    logic [2:0]         dn_reg, dn_next;
    logic [383:0]       bp122_reg, bp123_reg, bp124_reg;

    vec3_t        trans_w;
    logic [383:0] res_data;

    logic         out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;
    logic [383:0] out_data_reg, out_data_next, skid_data_reg, skid_data_next;
    logic         push;

    assign en = ~skid_vld_reg;
    assign s_tready = en;

    always_comb begin
        int ia;
        int ib;
        logic [49:0] smag;
        vec3_t pos_v;
        vec3_t basis [3];

        look_w = in_reg[95:0];
        hint_w = in_reg[191:96];
        for (int i = 0; i < 3; i++) begin
            ia = (i == 2) ? 0 : i + 1;
            ib = (i == 0) ? 2 : i - 1;
            ca_next[2*i]   = $signed(hint_w[ia]) * $signed(look_w[ib]);
            ca_next[2*i+1] = $signed(hint_w[ib]) * $signed(look_w[ia]);
            cu_next[2*i]   = $signed(look_d[ia]) * $signed(right_w[ib]);
            cu_next[2*i+1] = $signed(look_d[ib]) * $signed(right_w[ia]);
            fw_next.neg[i] = look_w[i][WORD_W-1];
            fw_next.mag[i] = look_w[i][WORD_W-1] ? 64'(-33'($signed(look_w[i])))
                                                 : 64'(look_w[i]);
        end

        basis[0] = right_d;
        basis[1] = up_w;
        basis[2] = fwd_d;
        for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < 3; i++) begin
                dp_next[3*b+i] = $signed(basis[b][i]) * $signed(pos_d[i]);
            end
        end
        for (int b = 0; b < 3; b++) begin
            ds_next[b] = 51'(dp_reg[3*b]) + 51'(dp_reg[3*b+1]) + 51'(dp_reg[3*b+2]);
            dn_next[b] = ds_reg[b][50];
            smag = ds_reg[b][50] ? 50'(-ds_reg[b]) : ds_reg[b][49:0];
            dq_next[b] = 34'((smag + 50'(1 << (FRAC_W - 1))) >> FRAC_W);
        end

        pos_v = bp124_reg[383:288];
        for (int b = 0; b < 3; b++) begin
            if (inverse_mode_reg) begin
                trans_w[b] = pos_v[b];
            end else if (dn_reg[b]) begin
                trans_w[b] = (dq_reg[b] > 34'h07fffffff) ? 32'h7fffffff : dq_reg[b][31:0];
            end else begin
                trans_w[b] = (dq_reg[b] > 34'h080000000) ? 32'h80000000 : -dq_reg[b][31:0];
            end
        end
        res_data = {trans_w, bp124_reg[287:0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg    <= s_tdata;
            ca_reg    <= ca_next;
            fw_reg    <= fw_next;
            rv_reg    <= cross_sm(ca_reg);
            fw3_reg   <= fw_reg;
            cu_reg    <= cu_next;
            uv_reg    <= cross_sm(cu_reg);
            dp_reg    <= dp_next;
            bp122_reg <= {pos_d, fwd_d, up_w, right_d};
            ds_reg    <= ds_next;
            bp123_reg <= bp122_reg;
            dq_reg    <= dq_next;
            dn_reg    <= dn_next;
            bp124_reg <= bp123_reg;
        end
    end

    lvm_norm u_norm_right (.aclk(aclk), .en(en), .vec_i(rv_reg),  .unit_o(right_w));
    lvm_norm u_norm_fwd   (.aclk(aclk), .en(en), .vec_i(fw3_reg), .unit_o(fwd_w));
    lvm_norm u_norm_up    (.aclk(aclk), .en(en), .vec_i(uv_reg),  .unit_o(up_w));

    lvm_delay #(.WIDTH(96), .DEPTH(LINE_LAT)) u_dly_look (
        .aclk(aclk), .en(en), .d_i(in_reg[95:0]), .q_o(look_d)
    );
    lvm_delay #(.WIDTH(96), .DEPTH(LINE_LAT)) u_dly_right (
        .aclk(aclk), .en(en), .d_i(right_w), .q_o(right_d)
    );
    lvm_delay #(.WIDTH(96), .DEPTH(LINE_LAT)) u_dly_fwd (
        .aclk(aclk), .en(en), .d_i(fwd_w), .q_o(fwd_d)
    );
    lvm_delay #(.WIDTH(96), .DEPTH(2*LINE_LAT)) u_dly_pos (
        .aclk(aclk), .en(en), .d_i(in_reg[287:192]), .q_o(pos_d)
    );

    assign push = en & vld_reg[PIPE_LAT-1];

    always_comb begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_next  = 1'b1;
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end else begin
                out_vld_next  = push;
                out_data_next = res_data;
            end
        end else if (push) begin
            skid_vld_next  = 1'b1;
            skid_data_next = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg          <= '0;
            out_vld_reg      <= 1'b0;
            skid_vld_reg     <= 1'b0;
            inverse_mode_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
            end
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
            if (cfg_we) begin
                inverse_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PIPE_LAT-1] && out_vld_reg && !m_tready && !skid_vld_reg)
        |=> skid_vld_reg)
        else $error("finished beat was not caught by the skid register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && m_tready) |=> (out_vld_reg && !skid_vld_reg))
        else $error("skid register did not move into the output register");
`endif

endmodule

`default_nettype wire
